// ===== src/edst_pkg.sv =====
// shared types and constants for the streaming euclidean distance block
// no dependencies; every other file imports this package
package edst_pkg;

  // element and field widths
  localparam int IN_W       = 16;
  localparam int ELEM_WIDTH = 16;
  localparam int MAX_DIM    = 1024;
  localparam int MAG_W      = ELEM_WIDTH + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);

  // accumulator and root widths
  localparam int SUM_W  = 44;
  localparam int DIST_W = 22;
  localparam int ITER   = SUM_W / 2;
  localparam int STEP_W = $clog2(ITER);

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [63:0]      ROOT_MAX = 64'((64'd1 << DIST_W) - 64'd1);

  // queue between accumulator and root unit
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // finished sum of one vector pair
  typedef struct packed {
    logic             sat;
    logic [SUM_W-1:0] sum;
  } sum_res_t;

  // root unit sequencer states
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_CALC,
    SQ_DONE
  } sq_state_t;

endpackage

// ===== src/edst_if.sv =====
// channel interfaces for the input element pairs and the distance results
// depends on edst_pkg
interface edst_in_if import edst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] element_a;
  logic signed [IN_W-1:0] element_b;
  logic                   last_element;

  modport source (output valid, output element_a, output element_b,
                  output last_element, input ready);
  modport sink   (input valid, input element_a, input element_b,
                  input last_element, output ready);
endinterface

interface edst_out_if import edst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// ===== src/euclidean_distance_stream.sv =====
// top level of the streaming euclidean distance block
// depends on edst_pkg, edst_if, edst_front, edst_fifo, edst_sqrt
//
// Takes one element pair per cycle (valid/ready on in_ch) and, on the pair
// flagged last, returns floor(sqrt(sum of squared differences)) on out_ch
// with an overflow flag for a saturated sum or a vector longer than MAX_DIM.
// The front end is a three-stage pipe (difference, square, accumulate) that
// sustains one pair per clock. Finished sums go through a four-entry queue
// to a bit-serial root unit that handles one vector at a time (load, 22 root
// steps, result register) plus the wait for out_ch.ready. Vectors no shorter
// than that root sequence stream at one pair per cycle; shorter vectors are
// limited by the root unit once the queue fills. No clearing pass after reset.
module euclidean_distance_stream import edst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  edst_in_if.sink    in_ch,
  edst_out_if.source out_ch
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  sum_res_t push_data;
  sum_res_t pop_data;

  // accumulator
  edst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // queue of finished sums
  edst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // square root and result
  edst_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== src/edst_fifo.sv =====
// small register queue of finished sums between accumulator and root unit
// depends on edst_pkg
module edst_fifo import edst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sum_res_t push_data,
  output logic     full,
  input  logic     pop,
  output sum_res_t pop_data,
  output logic     empty
);

  sum_res_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/edst_front.sv =====
// front end: takes element pairs, squares differences, accumulates per vector
// depends on edst_pkg and edst_in_if
module edst_front import edst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  edst_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     push,
  output sum_res_t push_data
);

  logic                    adv;
  logic                    acc_in;
  logic signed [MAG_W-1:0] a_x;
  logic signed [MAG_W-1:0] b_x;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic                    over;
  logic                    bad;

  logic [CNT_W-1:0]        cnt_r;
  logic                    s1_valid_r;
  logic [MAG_W-1:0]        s1_mag_r;
  logic                    s1_bad_r;
  logic                    s1_last_r;
  logic                    s2_valid_r;
  logic [SQ_W-1:0]         s2_sq_r;
  logic                    s2_bad_r;
  logic                    s2_last_r;
  logic [SUM_W-1:0]        sum_r;
  logic                    sat_r;

  logic [SUM_W:0]          sum_ext;
  logic [SUM_W-1:0]        sum_nxt;
  logic                    sat_nxt;

  // whole pipe holds while a finished sum waits for queue space
  assign adv         = !(s2_valid_r && s2_last_r && q_full);
  assign in_ch.ready = adv;
  assign acc_in      = in_ch.valid && adv;

  // difference magnitude and length check
  assign a_x  = MAG_W'(signed'(in_ch.element_a[ELEM_WIDTH-1:0]));
  assign b_x  = MAG_W'(signed'(in_ch.element_b[ELEM_WIDTH-1:0]));
  assign diff = a_x - b_x;
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign over = (cnt_r >= CNT_W'(MAX_DIM));
  assign bad  = over || (64'(mag) > ROOT_MAX);

  // element counter, stops at the length limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc_in) begin
      if (in_ch.last_element) begin
        cnt_r <= '0;
      end else if (!over) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage payloads: magnitude, then square
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag_r  <= mag;
      s1_bad_r  <= bad;
      s1_last_r <= in_ch.last_element;
      s2_sq_r   <= SQ_W'(s1_mag_r) * SQ_W'(s1_mag_r);
      s2_bad_r  <= s1_bad_r;
      s2_last_r <= s1_last_r;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_ext = {1'b0, sum_r} + (SUM_W+1)'(s2_sq_r);
    if (s2_bad_r || sat_r || sum_ext[SUM_W]) begin
      sum_nxt = SUM_MAX;
      sat_nxt = 1'b1;
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sat_r <= 1'b0;
    end else if (adv && s2_valid_r) begin
      if (s2_last_r) begin
        sum_r <= '0;
        sat_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        sat_r <= sat_nxt;
      end
    end
  end

  // hand the finished vector sum to the queue
  assign push          = adv && s2_valid_r && s2_last_r;
  assign push_data.sum = sum_nxt;
  assign push_data.sat = sat_nxt;

endmodule

// ===== src/edst_sqrt.sv =====
// back end: bit-serial integer square root and result register
// depends on edst_pkg and edst_out_if
module edst_sqrt import edst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  sum_res_t    q_data,
  output logic        pop,
  edst_out_if.source  out_ch
);

  sq_state_t         state_r;
  sq_state_t         state_nxt;
  logic [SUM_W-1:0]  rem_r;
  logic [SUM_W-1:0]  root_r;
  logic [SUM_W-1:0]  bit_r;
  logic [STEP_W-1:0] step_r;
  logic              sat_r;
  logic [SUM_W-1:0]  trial;
  logic              take;

  assign trial = root_r + bit_r;
  assign take  = (rem_r >= trial);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: if (!q_empty)            state_nxt = SQ_CALC;
      SQ_CALC: if (step_r == '0)        state_nxt = SQ_DONE;
      SQ_DONE: if (out_ch.ready)        state_nxt = SQ_IDLE;
      default:                          state_nxt = SQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop             = 1'b0;
    out_ch.valid    = 1'b0;
    unique case (state_r)
      SQ_IDLE: pop          = !q_empty;
      SQ_CALC: pop          = 1'b0;
      SQ_DONE: out_ch.valid = 1'b1;
      default: pop          = 1'b0;
    endcase
  end

  assign out_ch.distance = root_r[DIST_W-1:0];
  assign out_ch.overflow = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // one result bit per cycle while in SQ_CALC; operands loaded on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      rem_r  <= q_data.sum;
      root_r <= '0;
      bit_r  <= SUM_W'(1) << (SUM_W - 2);
      step_r <= STEP_W'(ITER - 1);
      sat_r  <= q_data.sat;
    end else if (state_r == SQ_CALC) begin
      if (take) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r  <= bit_r >> 2;
      step_r <= step_r - 1'b1;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the streaming euclidean distance block
// depends on edst_pkg, edst_if and euclidean_distance_stream; predicts each
// distance from the accepted element pairs and checks every result item
module testbench;
  import edst_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_GAP      = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;

  // one expected result item
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_res_t;

  // how the elements of a random vector are chosen
  typedef enum int {
    FILL_UNIFORM,
    FILL_EXTREME,
    FILL_SMALL,
    FILL_EQUAL
  } fill_t;

  logic clk = 1'b0;
  logic rst_n;

  edst_in_if  in_ch ();
  edst_out_if out_ch ();

  euclidean_distance_stream dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // distance predictor state
  logic [SUM_W-1:0] pred_sum;
  int               pred_count;
  logic             pred_sat;

  dist_res_t expected_dists[$];
  dist_res_t due_dist;
  int        mismatches = 0;
  int        items_sent = 0;

  // pacing of both sides
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  // floor square root, one result bit at a time from the top
  function automatic logic [DIST_W-1:0] floor_sqrt(input logic [SUM_W-1:0] n);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] trial;
    root = '0;
    for (int i = DIST_W - 1; i >= 0; i--) begin
      trial = root | (DIST_W'(1) << i);
      if (64'(trial) * 64'(trial) <= 64'(n)) root = trial;
    end
    return root;
  endfunction

  // fold one accepted pair into the running sum; returns 1 with a result on last
  function automatic bit accumulate_pair(input logic signed [IN_W-1:0] a,
                                         input logic signed [IN_W-1:0] b,
                                         input logic last,
                                         output dist_res_t res);
    longint      va;
    longint      vb;
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    va   = longint'($signed(a[ELEM_WIDTH-1:0]));
    vb   = longint'($signed(b[ELEM_WIDTH-1:0]));
    diff = va - vb;
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    res  = '0;
    if (pred_count >= MAX_DIM) begin
      pred_sat = 1'b1;
      pred_sum = SUM_MAX;
    end else begin
      pred_count++;
      if (!pred_sat) begin
        if (mag > ROOT_MAX) begin
          pred_sat = 1'b1;
          pred_sum = SUM_MAX;
        end else begin
          sq = mag * mag;
          if (sq > 64'(SUM_MAX) - 64'(pred_sum)) begin
            pred_sat = 1'b1;
            pred_sum = SUM_MAX;
          end else begin
            pred_sum = pred_sum + SUM_W'(sq);
          end
        end
      end
    end
    if (!last) return 1'b0;
    res.distance = floor_sqrt(pred_sum);
    res.overflow = pred_sat;
    pred_sum   = '0;
    pred_count = 0;
    pred_sat   = 1'b0;
    return 1'b1;
  endfunction

  // offer one element pair after a drawn gap and wait for its acceptance
  task automatic send_pair(input logic signed [IN_W-1:0] a,
                           input logic signed [IN_W-1:0] b,
                           input logic last);
    int        gap;
    dist_res_t res;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.element_a    <= a;
    in_ch.element_b    <= b;
    in_ch.last_element <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (accumulate_pair(a, b, last, res)) expected_dists.push_back(res);
    items_sent++;
  endtask

  // random element drawn in the given style
  function automatic logic signed [IN_W-1:0] pick_element(input fill_t fill);
    case (fill)
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return IN_W'(-32768);
          1: return IN_W'(32767);
          2: return IN_W'(-1);
          3: return IN_W'(1);
          default: return '0;
        endcase
      end
      FILL_SMALL: return IN_W'(int'($urandom_range(0, 64)) - 32);
      default:    return IN_W'($urandom());
    endcase
  endfunction

  // one whole vector pair, last flag on its final item
  task automatic send_vector(input int len, input fill_t fill);
    logic signed [IN_W-1:0] a;
    logic signed [IN_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = pick_element(fill);
      b = (fill == FILL_EQUAL) ? a : pick_element(fill);
      send_pair(a, b, i == len - 1);
    end
  endtask

  // stop offering until every expected distance has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_dists.size() != 0);
  endtask

  // field extremes, exact and inexact roots, one-pair and short multi-pair vectors
  task automatic test_directed();
    send_pair(0, 0, 1'b1);
    send_pair(32767, -32768, 1'b1);
    send_pair(-32768, 32767, 1'b1);
    send_pair(-32768, -32768, 1'b1);
    send_pair(-1, 0, 1'b1);
    send_pair(3, 0, 1'b0);
    send_pair(0, 4, 1'b1);
    send_pair(1, 0, 1'b0);
    send_pair(0, 1, 1'b1);
    send_pair(16'sh5555, 16'shAAAA, 1'b0);
    send_pair(16'shAAAA, 16'sh5555, 1'b1);
    for (int i = 0; i < 4; i++) send_pair(32767, -32768, i == 3);
    send_pair(7, 7, 1'b0);
    send_pair(100, -100, 1'b1);
    wait_for_results();
  endtask

  // maximum differences over MAX_DIM + 1 pairs, one pair past the limit, then a one-pair vector
  task automatic test_length_limit();
    for (int i = 0; i <= MAX_DIM; i++) begin
      if (i % 2 == 0) send_pair(-32768, 32767, i == MAX_DIM);
      else send_pair(32767, -32768, i == MAX_DIM);
    end
    send_pair(-5, 7, 1'b1);
    wait_for_results();
  endtask

  // long receiver hold-off while short vectors keep coming
  task automatic test_backpressure();
    hold_requests <= hold_requests + 1;
    tx_calm = 1'b1;
    for (int v = 0; v < 80; v++)
      send_vector($urandom_range(1, 2), fill_t'($urandom_range(0, 3)));
    tx_calm = 1'b0;
    wait_for_results();
  endtask

  // random vectors, mostly short, a few long
  task automatic test_random();
    int    start;
    int    roll;
    int    len;
    fill_t fill;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) len = $urandom_range(1, 8);
      else if (roll < 85) len = $urandom_range(9, 40);
      else if (roll < 97) len = $urandom_range(41, 200);
      else len = $urandom_range(201, 400);
      fill = fill_t'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
      send_vector(len, fill);
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end
    tx_calm = 1'b0;
  endtask

  // result side: ready pacing and comparison with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dists.size() == 0) begin
          $error("unexpected result item: distance %0d overflow %0d",
                 out_ch.distance, out_ch.overflow);
          mismatches++;
        end else begin
          due_dist = expected_dists.pop_front();
          if (out_ch.distance !== due_dist.distance) begin
            $error("distance: expected %0d, got %0d", due_dist.distance, out_ch.distance);
            mismatches++;
          end
          if (out_ch.overflow !== due_dist.overflow) begin
            $error("overflow: expected %0d, got %0d", due_dist.overflow, out_ch.overflow);
            mismatches++;
          end
        end
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no item moved for %0d cycles", STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // reset, the test sequence and the final verdict
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.element_a    = '0;
    in_ch.element_b    = '0;
    in_ch.last_element = 1'b0;
    pred_sum           = '0;
    pred_count         = 0;
    pred_sat           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_length_limit();
    test_backpressure();
    test_random();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
